// ===== rtl/rmsef_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsef_pkg
// Shared types and constants for the RMS envelope follower.
// ----------------------------------------------------------------------------
package rmsef_pkg;

    localparam int unsigned TEN_LOG10_2_Q24 = 32'd50504453;
    localparam int          DB_FLOOR_Q88    = -24576;
    localparam int          DB_FLOOR_MAG    = 24576;
    localparam int          LOG_FRAC_BITS   = 16;

    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_RELEASE = 2'd1;
    localparam logic [1:0] REG_LOG     = 2'd2;
    localparam logic [1:0] REG_STEREO  = 2'd3;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SQUARE,
        OP_DIFF,
        OP_MUL,
        OP_UPDATE,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_NORM_INIT,
        OP_NORM,
        OP_LOG_INIT,
        OP_LOG,
        OP_DB_MUL,
        OP_LIN_OUT,
        OP_DB_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic log_mode;
        logic env_zero;
        logic norm_done;
    } status_t;

endpackage

// ===== rtl/rmsef_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmsef_ctrl
// Sequencer for the envelope follower: steps the datapath through square,
// smoothing multiply, and root or logarithm, and owns the result handshake.
// ----------------------------------------------------------------------------
module rmsef_ctrl
    import rmsef_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output cmd_t    cmd,
    input  status_t status
);

    localparam int MAXC0 = (COEF_WIDTH > SAMPLE_WIDTH) ? COEF_WIDTH : SAMPLE_WIDTH;
    localparam int MAXC  = (MAXC0 > LOG_FRAC_BITS) ? MAXC0 : LOG_FRAC_BITS;
    localparam int CNT_W = $clog2(MAXC + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_DIFF,
        S_MUL,
        S_UPDATE,
        S_BRANCH,
        S_SQRT,
        S_NORM,
        S_LOG,
        S_DB_MUL,
        S_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign fire      = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_IDLE;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.op     = OP_SQUARE;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                cnt_next   = CNT_W'(COEF_WIDTH - 1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                if (cnt_reg == '0)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_UPDATE:
            begin
                cmd.op     = OP_UPDATE;
                state_next = S_BRANCH;
            end
            S_BRANCH:
            begin
                if (status.log_mode)
                begin
                    cmd.op     = OP_NORM_INIT;
                    state_next = status.env_zero ? S_FIN : S_NORM;
                end
                else
                begin
                    cmd.op     = OP_SQRT_INIT;
                    cnt_next   = CNT_W'(SAMPLE_WIDTH - 1);
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_NORM:
            begin
                if (status.norm_done)
                begin
                    cmd.op     = OP_LOG_INIT;
                    cnt_next   = CNT_W'(LOG_FRAC_BITS - 1);
                    state_next = S_LOG;
                end
                else
                begin
                    cmd.op = OP_NORM;
                end
            end
            S_LOG:
            begin
                cmd.op = OP_LOG;
                if (cnt_reg == '0)
                begin
                    state_next = S_DB_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DB_MUL:
            begin
                cmd.op     = OP_DB_MUL;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fire)
                begin
                    cmd.op         = status.log_mode ? OP_DB_OUT : OP_LIN_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/rmsef_datapath.sv =====
// ----------------------------------------------------------------------------
// rmsef_datapath
// Configuration registers, envelope state, shift-add smoothing multiplier,
// digit-by-digit square root and squaring log2 unit.
// ----------------------------------------------------------------------------
module rmsef_datapath
    import rmsef_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [COEF_WIDTH-1:0]          cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_left,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_right,
    input  cmd_t                           cmd,
    output status_t                        status,
    output logic signed [SAMPLE_WIDTH:0]   level
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CW   = COEF_WIDTH;
    localparam int EW   = 2 * SW - 1;
    localparam int AW   = SW + 1;
    localparam int SSW  = SW + 2;
    localparam int MW   = EW + CW;
    localparam int RW   = SW + 3;
    localparam int OW   = SW + 1;
    localparam int PW   = $clog2(EW);
    localparam int L2W  = PW + LOG_FRAC_BITS;
    localparam int PRW  = L2W + 27;
    localparam int QW   = PRW - 32;
    localparam logic [L2W-1:0] FULL = L2W'(EW - 1) << LOG_FRAC_BITS;

    logic [CW-1:0]  attack_reg, release_reg;
    logic           log_reg, stereo_reg;
    logic [EW-1:0]  env_reg;
    logic [AW-1:0]  abs_l_reg, abs_r_reg;
    logic [EW-1:0]  x_reg;
    logic           rise_reg;
    logic [CW-1:0]  coef_sh_reg;
    logic [MW-1:0]  d_sh_reg, acc_reg;
    logic [2*SW-1:0] v_sh_reg;
    logic [RW-1:0]  rem_reg;
    logic [SW-1:0]  root_reg;
    logic [EW-1:0]  norm_reg;
    logic [PW-1:0]  p_reg;
    logic [31:0]    lx_reg;
    logic [LOG_FRAC_BITS-1:0] frac_reg;
    logic           ge_reg;
    logic [PRW-1:0] prod_reg;
    logic [OW-1:0]  level_reg;

    logic [AW-1:0]  ext_l, ext_r;
    logic [SSW-1:0] sum;
    logic [2*SSW-1:0] sq;
    logic [EW-1:0]  sc, x_sq;
    logic [RW-1:0]  rem_t, trial;
    logic [EW+31:0] norm_full;
    logic [63:0]    lsq;
    logic [32:0]    lt;
    logic [L2W-1:0] l2;
    logic [PRW-1:0] prod_rnd;
    logic [QW-1:0]  q;
    logic signed [QW:0] dbv;
    logic [OW-1:0]  db_level;

    assign ext_l = {sample_left[SW-1], sample_left};
    assign ext_r = {sample_right[SW-1], sample_right};
    assign sum   = stereo_reg ? (SSW'(abs_l_reg) + SSW'(abs_r_reg)) : SSW'(abs_l_reg);
    assign sq    = sum * sum;
    assign x_sq  = stereo_reg ? EW'(sq >> 2) : EW'(sq);
    assign sc    = EW'(acc_reg >> CW);
    assign rem_t = {rem_reg[RW-3:0], v_sh_reg[2*SW-1 -: 2]};
    assign trial = RW'({root_reg, 2'b01});
    assign norm_full = {norm_reg, 32'd0};
    assign lsq   = lx_reg * lx_reg;
    assign lt    = lsq[63:31];
    assign l2    = {p_reg, frac_reg};
    assign prod_rnd = prod_reg + (PRW'(1) << 31);
    assign q     = prod_rnd[PRW-1:32];
    assign dbv   = -$signed({1'b0, q});

    always_comb
    begin
        if (ge_reg)
        begin
            db_level = '0;
        end
        else if (q >= QW'(DB_FLOOR_MAG))
        begin
            db_level = OW'(DB_FLOOR_Q88);
        end
        else
        begin
            db_level = OW'(dbv);
        end
        if (env_reg == '0)
        begin
            db_level = OW'(DB_FLOOR_Q88);
        end
    end

    assign status.log_mode  = log_reg;
    assign status.env_zero  = (env_reg == '0);
    assign status.norm_done = norm_reg[EW-1];
    assign level            = $signed(level_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= '0;
            release_reg <= '0;
            log_reg     <= 1'b0;
            stereo_reg  <= 1'b0;
            env_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ATTACK:  attack_reg  <= cfg_data;
                    REG_RELEASE: release_reg <= cfg_data;
                    REG_LOG:     log_reg     <= cfg_data[0];
                    REG_STEREO:  stereo_reg  <= cfg_data[0];
                    default:     ;
                endcase
            end
            if (cmd.op == OP_UPDATE)
            begin
                env_reg <= rise_reg ? (x_reg - sc) : (x_reg + sc);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                abs_l_reg <= sample_left[SW-1] ? -ext_l : ext_l;
                abs_r_reg <= sample_right[SW-1] ? -ext_r : ext_r;
            end
            OP_SQUARE:
            begin
                x_reg <= x_sq;
            end
            OP_DIFF:
            begin
                rise_reg    <= (x_reg > env_reg);
                coef_sh_reg <= (x_reg > env_reg) ? attack_reg : release_reg;
                d_sh_reg    <= (x_reg > env_reg) ? MW'(x_reg - env_reg) : MW'(env_reg - x_reg);
                acc_reg     <= '0;
            end
            OP_MUL:
            begin
                if (coef_sh_reg[0])
                begin
                    acc_reg <= acc_reg + d_sh_reg;
                end
                coef_sh_reg <= coef_sh_reg >> 1;
                d_sh_reg    <= d_sh_reg << 1;
            end
            OP_SQRT_INIT:
            begin
                v_sh_reg <= {1'b0, env_reg};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_SQRT:
            begin
                v_sh_reg <= v_sh_reg << 2;
                if (rem_t >= trial)
                begin
                    rem_reg  <= rem_t - trial;
                    root_reg <= {root_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[SW-2:0], 1'b0};
                end
            end
            OP_NORM_INIT:
            begin
                norm_reg <= env_reg;
                p_reg    <= PW'(EW - 1);
            end
            OP_NORM:
            begin
                norm_reg <= norm_reg << 1;
                p_reg    <= p_reg - 1'b1;
            end
            OP_LOG_INIT:
            begin
                lx_reg   <= norm_full[EW+31 -: 32];
                frac_reg <= '0;
            end
            OP_LOG:
            begin
                lx_reg   <= lt[32] ? lt[32:1] : lt[31:0];
                frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], lt[32]};
            end
            OP_DB_MUL:
            begin
                ge_reg   <= (l2 >= FULL);
                prod_reg <= PRW'(FULL - l2) * PRW'(TEN_LOG10_2_Q24);
            end
            OP_LIN_OUT:
            begin
                level_reg <= {1'b0, root_reg};
            end
            OP_DB_OUT:
            begin
                level_reg <= db_level;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/rms_envelope_follower_core.sv =====
// ----------------------------------------------------------------------------
// rms_envelope_follower_core
// RMS envelope follower with attack/release smoothing, linear or dB output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one sample pair per item; the
//   right sample is used only in stereo mode. Output channel
//   (out_valid/out_ready) gives one level per item.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//   An accepted item is squared and compared with the envelope, smoothed by
//   the shift-add multiplier over COEF_WIDTH coefficient bits, written to the
//   envelope and branched on the mode. Linear mode then takes the root one
//   bit at a time over SAMPLE_WIDTH bits and outputs it. Decibel mode
//   normalizes, forms LOG_FRAC_BITS log2 fraction bits by squaring, does one
//   multiply and outputs; a zero envelope goes straight to the output. One
//   item is in work at a time; in_ready is high only while the sequencer is
//   idle.
//   A finished level waits in the output register; a new item may be taken
//   meanwhile, and its result is held back until the old one is taken.
//   Reset clears the configuration registers, the envelope and the output valid flag.
// ----------------------------------------------------------------------------
module rms_envelope_follower_core
    import rmsef_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [COEF_WIDTH-1:0]          cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_left,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_right,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH:0]   level
);

    cmd_t    cmd;
    status_t status;

    rmsef_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    rmsef_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .cmd          (cmd),
        .status       (status),
        .level        (level)
    );

endmodule

// ===== rtl/rmsef_checker.sv =====
// ----------------------------------------------------------------------------
// rmsef_checker
// Port-level checks for the envelope follower, bound to the top level.
// ----------------------------------------------------------------------------
module rmsef_checker #(
    parameter int SAMPLE_WIDTH = 16
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [SAMPLE_WIDTH:0] level
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level))
        else $error("result changed while stalled");

    a_busy_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while busy");

    a_busy_later: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 !in_ready)
        else $error("sequencer returned idle too early");

endmodule

bind rms_envelope_follower_core rmsef_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_rmsef_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rms_envelope_follower_core: drives sample items
// under random gaps and stalls, predicts each envelope level in linear and
// decibel modes, and compares results in order.
// ----------------------------------------------------------------------------
module tb
    import rmsef_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = 16;
    localparam int CW = 16;
    localparam longint CYCLE_LIMIT = 400000;

    class level_scoreboard;
        logic [15:0] attack;
        logic [15:0] rel;
        logic        log_mode;
        logic        stereo;
        longint unsigned sq_env;
        logic signed [16:0] pending[$];
        int errors;
        int checked;

        function new();
            attack = 0;
            rel = 0;
            log_mode = 0;
            stereo = 0;
            sq_env = 0;
            errors = 0;
            checked = 0;
        endfunction

        function longint unsigned mag(logic [15:0] s);
            if (s[15])
                return 65536 - longint'(s);
            return longint'(s);
        endfunction

        function longint unsigned scale(longint unsigned c, longint unsigned d);
            return (c * d) >> CW;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        function longint unsigned log2q16(longint unsigned v);
            int p;
            longint unsigned x;
            longint unsigned res;
            p = 63;
            while (p > 0 && v[p] == 1'b0)
                p--;
            if (p >= 31)
                x = v >> (p - 31);
            else
                x = v << (31 - p);
            res = longint'(p) << 16;
            for (int i = 15; i >= 0; i--)
            begin
                x = (x * x) >> 31;
                if (x >= (64'd1 << 32))
                begin
                    res |= 64'd1 << i;
                    x >>= 1;
                end
            end
            return res;
        endfunction

        function int decibels(longint unsigned e);
            longint unsigned l2;
            longint unsigned full;
            longint unsigned q;
            if (e == 0)
                return DB_FLOOR_Q88;
            l2 = log2q16(e);
            full = longint'(2 * (SW - 1)) << 16;
            if (l2 >= full)
                return 0;
            q = ((full - l2) * TEN_LOG10_2_Q24 + (64'd1 << 31)) >> 32;
            if (q >= DB_FLOOR_MAG)
                return DB_FLOOR_Q88;
            return -int'(q);
        endfunction

        function void note_item(logic [15:0] l, logic [15:0] r);
            longint unsigned x;
            longint unsigned s;
            if (stereo)
            begin
                s = mag(l) + mag(r);
                x = (s * s) >> 2;
            end
            else
                x = mag(l) * mag(l);
            if (x > sq_env)
                sq_env = x - scale(attack, x - sq_env);
            else
                sq_env = x + scale(rel, sq_env - x);
            if (log_mode)
                pending.push_back(17'(decibels(sq_env)));
            else
                pending.push_back(17'(root(sq_env)));
        endfunction

        function void check_level(logic signed [16:0] got);
            logic signed [16:0] want;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected level %0d", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want !== got)
            begin
                $display("%0t: level expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [1:0] cfg_index = 0;
    logic [CW-1:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [SW-1:0] sample_left = 0;
    logic signed [SW-1:0] sample_right = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [SW:0] level;

    level_scoreboard sb;
    int send_idle;
    int recv_idle;
    longint cycles;

    rms_envelope_follower_core #(.SAMPLE_WIDTH(SW), .COEF_WIDTH(CW)) u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .sample_left(sample_left), .sample_right(sample_right),
        .out_valid(out_valid), .out_ready(out_ready), .level(level)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rms_envelope_follower_core: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_level(level);
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            REG_ATTACK: sb.attack = val;
            REG_RELEASE: sb.rel = val;
            REG_LOG: sb.log_mode = val[0];
            default: sb.stereo = val[0];
        endcase
    endtask

    task automatic send_item(logic [15:0] l, logic [15:0] r);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        sample_left <= l;
        sample_right <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(l, r);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic setup(logic [15:0] a, logic [15:0] r, logic lg, logic st);
        drain();
        write_reg(REG_ATTACK, a);
        write_reg(REG_RELEASE, r);
        write_reg(REG_LOG, 16'(lg));
        write_reg(REG_STEREO, 16'(st));
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(15)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [15:0] a;
        logic [15:0] r;
        a = ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom);
        r = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
        setup(a, r, 1'($urandom), 1'($urandom));
        repeat (n)
            send_item(rand_sample(), rand_sample());
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        send_idle = 15;
        recv_idle = 57;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_item(16'h0000, 16'h7fff);
        send_item(16'h8000, 16'h1234);
        send_item(16'h7fff, 16'h8000);
        setup(16'h0000, 16'h0000, 1, 0);
        send_item(16'h0000, 16'h0000);
        send_item(16'h8000, 16'h0000);
        send_item(16'h0001, 16'h0000);
        send_item(16'h0000, 16'h0000);
        send_item(16'hffff, 16'h0000);
        setup(16'hffff, 16'hffff, 1, 1);
        send_item(16'h8000, 16'h8000);
        send_item(16'h7fff, 16'h0001);
        send_item(16'h0000, 16'h0000);
        setup(16'h8000, 16'hf000, 0, 1);
        send_item(16'h8000, 16'h7fff);
        send_item(16'h0000, 16'h8000);
        send_item(16'h0003, 16'hfffd);
        send_item(16'h0000, 16'h0000);
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                send_idle = 57;
                recv_idle = 15;
            end
            if (ph == 6)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            random_phase(55);
        end
        drain();
        $display("Ran %0d levels over mono/stereo, linear/dB and coefficient extremes.",
            sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("rms_envelope_follower_core: match");
        else
            $display("rms_envelope_follower_core: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/rmsef_pkg.sv
rtl/rmsef_ctrl.sv
rtl/rmsef_datapath.sv
rtl/rms_envelope_follower_core.sv
rtl/rmsef_checker.sv
bench/tb.sv
